/* sv/plus_minus_paren_evaluator_core_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the expression evaluator
// Checks compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PLUS_MINUS_PAREN_EVALUATOR_CORE_DEFINES_SVH
`define PLUS_MINUS_PAREN_EVALUATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PMPE_ASSERT_IMP(lbl, c, r, a, b) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
        else $error("evaluator check failed");
// next-cycle implication
`define PMPE_ASSERT_NXT(lbl, c, r, a, b) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
        else $error("evaluator check failed");
`else
`define PMPE_ASSERT_IMP(lbl, c, r, a, b)
`define PMPE_ASSERT_NXT(lbl, c, r, a, b)
`endif

`endif

/* sv/pmpe_pkg.sv */
// ---------------------------------------------------------------------------
// pmpe_pkg
// Character codes, status codes and shared types of the evaluator.
// ---------------------------------------------------------------------------
`default_nettype none

package pmpe_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEEP  = 2'd1,
        ST_CLOSE = 2'd2,
        ST_OPEN  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CLS_OTHER = 3'd0,
        CLS_DIGIT = 3'd1,
        CLS_PLUS  = 3'd2,
        CLS_MINUS = 3'd3,
        CLS_OPEN  = 3'd4,
        CLS_CLOSE = 3'd5
    } char_class_t;

    // stack operations requested by the step logic
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stk_ctrl_t;

    function automatic char_class_t char_class(input logic [7:0] c);
        char_class_t cls;
        cls = CLS_OTHER;
        if (c >= CH_ZERO && c <= CH_NINE)
            cls = CLS_DIGIT;
        else if (c == CH_PLUS)
            cls = CLS_PLUS;
        else if (c == CH_MINUS)
            cls = CLS_MINUS;
        else if (c == CH_OPEN)
            cls = CLS_OPEN;
        else if (c == CH_CLOSE)
            cls = CLS_CLOSE;
        else if (c == CH_SPACE)
            cls = CLS_OTHER;
        return cls;
    endfunction

endpackage

`default_nettype wire

/* sv/pmpe_char_if.sv */
// ---------------------------------------------------------------------------
// pmpe_char_if
// Character channel: one expression byte per item, with an end flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface pmpe_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

/* sv/pmpe_result_if.sv */
// ---------------------------------------------------------------------------
// pmpe_result_if
// Result channel: evaluated value and status code.
// ---------------------------------------------------------------------------
`default_nettype none

interface pmpe_result_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic [1:0]             status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

/* sv/plus_minus_paren_evaluator_core.sv */
// ---------------------------------------------------------------------------
// plus_minus_paren_evaluator_core
// Streaming evaluator for decimal +/- expressions with parentheses.
// ---------------------------------------------------------------------------
//
//   port     dir   payload              transfer
//   chars    in    ch[7:0], last        valid & ready
//   result   out   value[VW-1:0],       valid & ready
//                  status[1:0]
//
// One character per cycle while no last character waits on an unread result;
// a result goes valid once the last character has passed the input register
// and the result register. The step logic handles each character; the stack
// top lives in registers and the entry below it is prefetched from RAM.
// Reset clears the evaluator state and both valid flags; no RAM sweep.
// A stalled result blocks only a later last character; others keep flowing.
//
`default_nettype none

`include "plus_minus_paren_evaluator_core_defines.svh"

module plus_minus_paren_evaluator_core #(
    parameter int STACK_DEPTH = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    pmpe_char_if.sink    chars,
    pmpe_result_if.source result
);

    import pmpe_pkg::*;

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int VW = VALUE_WIDTH;

    logic          in_valid_reg;
    logic [7:0]    in_ch_reg;
    logic          in_last_reg;
    logic          advance;

    logic [VW-1:0] sum_reg;
    logic [VW-1:0] sum_next;
    logic [VW-1:0] cur_reg;
    logic [VW-1:0] cur_next;
    logic          sign_reg;
    logic          sign_next;
    status_t       err_reg;
    status_t       err_next;

    stk_ctrl_t     ctrl;
    logic [LW-1:0] level;
    logic [VW-1:0] top_sum;
    logic          top_sign;

    logic [VW-1:0] res_value;
    status_t       res_status;
    logic          out_valid_reg;
    logic [VW-1:0] out_value_reg;
    logic [1:0]    out_status_reg;

    // hold a last character while the previous result is still unread
    assign advance     = in_valid_reg && (!in_last_reg || !out_valid_reg || result.ready);
    assign chars.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            in_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            in_ch_reg   <= chars.ch;
            in_last_reg <= chars.last;
        end
    end

    pmpe_step #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_step (
        .ch        (in_ch_reg),
        .last      (in_last_reg),
        .sum       (sum_reg),
        .cur       (cur_reg),
        .sign      (sign_reg),
        .err       (err_reg),
        .level     (level),
        .top_sum   (top_sum),
        .top_sign  (top_sign),
        .sum_next  (sum_next),
        .cur_next  (cur_next),
        .sign_next (sign_next),
        .err_next  (err_next),
        .ctrl      (ctrl),
        .value     (res_value),
        .status    (res_status)
    );

    pmpe_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (advance ? ctrl : stk_ctrl_t'('0)),
        .push_sum  (sum_reg),
        .push_sign (sign_reg),
        .level     (level),
        .top_sum   (top_sum),
        .top_sign  (top_sign)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            cur_reg  <= '0;
            sign_reg <= 1'b0;
            err_reg  <= ST_OK;
        end
        else if (advance)
        begin
            sum_reg  <= sum_next;
            cur_reg  <= cur_next;
            sign_reg <= sign_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.value  = out_value_reg;
    assign result.status = out_status_reg;

    `PMPE_ASSERT_IMP(a_err_value_zero, clk, rst_n,
        result.valid && (result.status != ST_OK), result.value == '0)
    `PMPE_ASSERT_IMP(a_level_bound, clk, rst_n, 1'b1, level <= LW'(STACK_DEPTH))
    `PMPE_ASSERT_NXT(a_clear_after_last, clk, rst_n, advance && in_last_reg,
        (level == '0) && (err_reg == ST_OK) && result.valid)

endmodule

`default_nettype wire

/* sv/pmpe_ram.sv */
// ---------------------------------------------------------------------------
// pmpe_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pmpe_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 31
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/pmpe_stack.sv */
// ---------------------------------------------------------------------------
// pmpe_stack
// Bounded stack of saved sums and signs. The top entry sits in registers,
// the entries below it in a RAM whose next-below entry is always prefetched.
// ---------------------------------------------------------------------------
`default_nettype none

module pmpe_stack #(
    parameter int STACK_DEPTH = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire pmpe_pkg::stk_ctrl_t                   ctrl,
    input  wire logic [VALUE_WIDTH-1:0]                push_sum,
    input  wire logic                                  push_sign,
    output logic      [$clog2(STACK_DEPTH+1)-1:0]      level,
    output logic      [VALUE_WIDTH-1:0]                top_sum,
    output logic                                       top_sign
);

    import pmpe_pkg::*;

    localparam int LW       = $clog2(STACK_DEPTH + 1);
    localparam int RAM_DEPTH = (STACK_DEPTH > 1) ? STACK_DEPTH - 1 : 1;
    localparam int AW       = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int EW       = VALUE_WIDTH + 1;

    logic [LW-1:0] level_reg;
    logic [LW-1:0] level_next;
    logic [LW-1:0] level_m1;
    logic [LW-1:0] level_next_m2;
    logic [VALUE_WIDTH-1:0] top_sum_reg;
    logic                   top_sign_reg;
    logic          fwd_valid_reg;
    logic [EW-1:0] fwd_data_reg;
    logic [EW-1:0] ram_rdata;
    logic [EW-1:0] below;
    logic          ram_we;

    always_comb
    begin
        priority if (ctrl.clear)
            level_next = '0;
        else if (ctrl.push)
            level_next = level_reg + LW'(1);
        else if (ctrl.pop)
            level_next = level_reg - LW'(1);
        else
            level_next = level_reg;
    end

    assign level_m1      = level_reg - LW'(1);
    assign level_next_m2 = level_next - LW'(2);
    // old top moves into the RAM when a push lands on a non-empty stack
    assign ram_we        = ctrl.push && (level_reg != '0);
    assign below         = fwd_valid_reg ? fwd_data_reg : ram_rdata;

    pmpe_ram #(
        .WIDTH (EW),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (level_m1[AW-1:0]),
        .wdata ({top_sign_reg, top_sum_reg}),
        .raddr (level_next_m2[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            // the RAM read of an entry written this cycle returns stale data
            fwd_valid_reg <= ram_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            fwd_data_reg <= {top_sign_reg, top_sum_reg};
        end
        if (ctrl.push)
        begin
            top_sum_reg  <= push_sum;
            top_sign_reg <= push_sign;
        end
        else if (ctrl.pop)
        begin
            top_sum_reg  <= below[VALUE_WIDTH-1:0];
            top_sign_reg <= below[VALUE_WIDTH];
        end
    end

    assign level    = level_reg;
    assign top_sum  = top_sum_reg;
    assign top_sign = top_sign_reg;

endmodule

`default_nettype wire

/* sv/pmpe_step.sv */
// ---------------------------------------------------------------------------
// pmpe_step
// Next-state logic for one character, plus the end-of-expression result.
// ---------------------------------------------------------------------------
`default_nettype none

module pmpe_step #(
    parameter int STACK_DEPTH = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic [7:0]                        ch,
    input  wire logic                              last,
    input  wire logic [VALUE_WIDTH-1:0]            sum,
    input  wire logic [VALUE_WIDTH-1:0]            cur,
    input  wire logic                              sign,
    input  wire pmpe_pkg::status_t                 err,
    input  wire logic [$clog2(STACK_DEPTH+1)-1:0]  level,
    input  wire logic [VALUE_WIDTH-1:0]            top_sum,
    input  wire logic                              top_sign,
    output logic      [VALUE_WIDTH-1:0]            sum_next,
    output logic      [VALUE_WIDTH-1:0]            cur_next,
    output logic                                   sign_next,
    output pmpe_pkg::status_t                      err_next,
    output pmpe_pkg::stk_ctrl_t                    ctrl,
    output logic      [VALUE_WIDTH-1:0]            value,
    output pmpe_pkg::status_t                      status
);

    import pmpe_pkg::*;

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int VW = VALUE_WIDTH;

    char_class_t      cls;
    logic [3:0]       digit;
    logic [VW-1:0]    term;
    logic [VW-1:0]    folded;
    logic [VW-1:0]    inner_term;
    logic [VW-1:0]    sum_op;
    logic [VW-1:0]    cur_op;
    logic             sign_op;
    status_t          err_op;
    logic [LW-1:0]    level_op;
    logic             do_push;
    logic             do_pop;
    logic [VW-1:0]    final_sum;
    status_t          final_err;

    assign cls        = char_class(ch);
    assign digit      = ch[3:0];
    assign term       = sign ? (VW'(0) - cur) : cur;
    assign folded     = sum + term;
    assign inner_term = top_sign ? (VW'(0) - folded) : folded;

    always_comb
    begin
        sum_op   = sum;
        cur_op   = cur;
        sign_op  = sign;
        err_op   = err;
        level_op = level;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        unique case (cls)
            CLS_DIGIT:
            begin
                // cur * 10 + digit
                cur_op = {cur[VW-4:0], 3'b000} + {cur[VW-2:0], 1'b0} + VW'(digit);
            end
            CLS_PLUS, CLS_MINUS:
            begin
                sum_op  = folded;
                cur_op  = '0;
                sign_op = (cls == CLS_MINUS);
            end
            CLS_OPEN:
            begin
                if (level < LW'(STACK_DEPTH))
                begin
                    do_push  = 1'b1;
                    sum_op   = '0;
                    cur_op   = '0;
                    sign_op  = 1'b0;
                    level_op = level + LW'(1);
                end
                else if (err == ST_OK)
                begin
                    err_op = ST_DEEP;
                end
            end
            CLS_CLOSE:
            begin
                if (level != '0)
                begin
                    do_pop   = 1'b1;
                    sum_op   = top_sum + inner_term;
                    cur_op   = '0;
                    sign_op  = top_sign;
                    level_op = level - LW'(1);
                end
                else if (err == ST_OK)
                begin
                    err_op = ST_CLOSE;
                end
            end
            default:
            begin
                sum_op = sum;
            end
        endcase
    end

    assign final_sum = sum_op + (sign_op ? (VW'(0) - cur_op) : cur_op);

    always_comb
    begin
        if (err_op != ST_OK)
            final_err = err_op;
        else if (level_op != '0)
            final_err = ST_OPEN;
        else
            final_err = ST_OK;
    end

    assign value  = (final_err == ST_OK) ? final_sum : '0;
    assign status = final_err;

    // a finished expression leaves the evaluator cleared for the next one
    assign sum_next   = last ? '0 : sum_op;
    assign cur_next   = last ? '0 : cur_op;
    assign sign_next  = last ? 1'b0 : sign_op;
    assign err_next   = last ? ST_OK : err_op;
    assign ctrl.push  = do_push;
    assign ctrl.pop   = do_pop;
    assign ctrl.clear = last;

endmodule

`default_nettype wire
